@@ hw/rtl/epi_pkg.sv @@
// Shared types and constants for the edge and plane intersection block.
package epi_pkg;

	localparam int CoordW = 32;
	localparam int DiffW = 33;
	localparam int ProdW = 65;
	localparam int SumW = 67;
	localparam int QuoW = 33;
	localparam int FracBits = 32;
	localparam int IdxW = 8;

	localparam logic [IdxW-1:0] REG_PLANE_A = 8'd0;
	localparam logic [IdxW-1:0] REG_PLANE_B = 8'd1;
	localparam logic [IdxW-1:0] REG_PLANE_C = 8'd2;
	localparam logic [IdxW-1:0] REG_PLANE_D = 8'd3;

	// Per-edge data that rides alongside the divider.
	typedef struct packed {
		logic signed [CoordW-1:0] p2x;
		logic signed [CoordW-1:0] p2y;
		logic signed [CoordW-1:0] p2z;
		logic signed [DiffW-1:0] dx;
		logic signed [DiffW-1:0] dy;
		logic signed [DiffW-1:0] dz;
		logic hit;
		logic last;
	} epi_side_t;

	typedef struct packed {
		logic [SumW-1:0] rem;
		logic [SumW-1:0] dmag;
		logic [QuoW-1:0] q;
		epi_side_t side;
	} epi_div_t;

endpackage

@@ hw/rtl/epi_if.sv @@
// Channel interfaces: edge input, cut output and configuration write.
interface epi_edge_if;
	logic valid;
	logic ready;
	logic signed [31:0] first_x;
	logic signed [31:0] first_y;
	logic signed [31:0] first_z;
	logic signed [31:0] second_x;
	logic signed [31:0] second_y;
	logic signed [31:0] second_z;
	logic last_edge;
	modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		last_edge, input ready);
	modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		last_edge, output ready);
endinterface

interface epi_cut_if;
	logic valid;
	logic ready;
	logic hit;
	logic signed [31:0] cut_x;
	logic signed [31:0] cut_y;
	logic signed [31:0] cut_z;
	logic last_cut;
	modport source (output valid, hit, cut_x, cut_y, cut_z, last_cut, input ready);
	modport sink (input valid, hit, cut_x, cut_y, cut_z, last_cut, output ready);
endinterface

interface epi_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/edge_plane_intersection.sv @@
// Top level of the edge and plane intersection pipeline.
// Each word on edge_in is one mesh edge (p1 = first, p2 = second) and yields exactly one word
// on cut_out, in order. The block evaluates num = -(d + n.p2) and den = n.(p1 - p2) exactly,
// tests 0 <= num/den <= 1 exactly (a zero den is no hit), forms alpha with 32 fractional bits
// and reports p2 + alpha*(p1 - p2) rounded to nearest; a miss gives zero coordinates.
// The pipeline takes one edge every clock unless cut_out stalls and has four stages for the
// differences, products, sums and hit test, thirty-two divider stages (one quotient bit each),
// one stage for the alpha products and the output register. All stages advance together
// whenever the output register is empty or being taken, so a stall on cut_out holds every
// stage in place. Configuration writes are always accepted and should be made while idle.
module edge_plane_intersection (
	input  logic clk,
	input  logic arst_n,
	epi_edge_if.sink edge_in,
	epi_cut_if.source cut_out,
	epi_cfg_if.sink cfg
);

	localparam int CW = epi_pkg::CoordW;
	localparam int DW = epi_pkg::DiffW;
	localparam int PW = epi_pkg::ProdW;
	localparam int SW = epi_pkg::SumW;
	localparam int QW = epi_pkg::QuoW;

	// Plane registers.
	logic signed [CW-1:0] plane_a_q, plane_b_q, plane_c_q, plane_d_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_a_q <= '0;
			plane_b_q <= '0;
			plane_c_q <= 32'sd65536;
			plane_d_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				epi_pkg::REG_PLANE_A: plane_a_q <= cfg.data;
				epi_pkg::REG_PLANE_B: plane_b_q <= cfg.data;
				epi_pkg::REG_PLANE_C: plane_c_q <= cfg.data;
				epi_pkg::REG_PLANE_D: plane_d_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves in lock step with the output register.
	logic adv;
	logic out_valid_q;
	assign adv = !out_valid_q || cut_out.ready;
	assign edge_in.ready = adv;

	// Stage 1: register the edge and the endpoint differences.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	epi_pkg::epi_side_t side_s1, side_s2, side_s3, side_s5;
	epi_pkg::epi_side_t side_in;

	always_comb begin
		side_in.p2x = edge_in.second_x;
		side_in.p2y = edge_in.second_y;
		side_in.p2z = edge_in.second_z;
		side_in.dx = DW'(edge_in.first_x) - DW'(edge_in.second_x);
		side_in.dy = DW'(edge_in.first_y) - DW'(edge_in.second_y);
		side_in.dz = DW'(edge_in.first_z) - DW'(edge_in.second_z);
		side_in.hit = 1'b0;
		side_in.last = edge_in.last_edge;
	end

	// Stage 2: the six products of the two dot products.
	logic signed [PW-1:0] nx_s2, ny_s2, nz_s2, dx_s2, dy_s2, dz_s2;
	// Stage 3: exact numerator and denominator.
	logic signed [SW-1:0] num_s3, den_s3;
	// Stage 4: magnitudes, hit test and divider seed.
	epi_pkg::epi_div_t div_s4;

	logic num_neg, den_neg, num_zero, den_zero, is_hit, is_one;
	logic [SW-1:0] num_mag, den_mag;
	epi_pkg::epi_side_t side_seed;

	always_comb begin
		num_neg = num_s3[SW-1];
		den_neg = den_s3[SW-1];
		num_zero = num_s3 == '0;
		den_zero = den_s3 == '0;
		num_mag = num_neg ? SW'(-num_s3) : SW'(num_s3);
		den_mag = den_neg ? SW'(-den_s3) : SW'(den_s3);
		is_hit = !den_zero && (num_zero || (num_neg == den_neg)) && (num_mag <= den_mag);
		is_one = num_mag == den_mag;
		side_seed = side_s3;
		side_seed.hit = is_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= edge_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;

			nx_s2 <= PW'(plane_a_q) * PW'(side_s1.p2x);
			ny_s2 <= PW'(plane_b_q) * PW'(side_s1.p2y);
			nz_s2 <= PW'(plane_c_q) * PW'(side_s1.p2z);
			dx_s2 <= PW'(plane_a_q) * PW'(side_s1.dx);
			dy_s2 <= PW'(plane_b_q) * PW'(side_s1.dy);
			dz_s2 <= PW'(plane_c_q) * PW'(side_s1.dz);
			side_s2 <= side_s1;

			num_s3 <= -(SW'(nx_s2) + SW'(ny_s2) + SW'(nz_s2) + (SW'(plane_d_q) <<< 16));
			den_s3 <= SW'(dx_s2) + SW'(dy_s2) + SW'(dz_s2);
			side_s3 <= side_s2;

			// At alpha of one the leading quotient bit is set and the remainder cleared.
			div_s4.rem <= (is_hit && !is_one) ? num_mag : '0;
			div_s4.dmag <= den_mag;
			div_s4.q <= QW'(is_hit && is_one);
			div_s4.side <= side_seed;
		end
	end

	// Stages 5 to 36: the quotient bits of alpha.
	logic div_valid;
	epi_pkg::epi_div_t div_out;

	epi_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(valid_s4),
		.in_data(div_s4),
		.out_valid(div_valid),
		.out_data(div_out)
	);

	// Stage 37: alpha times each edge extent magnitude.
	logic [2*QW-1:0] mx_s5, my_s5, mz_s5;
	logic [DW-1:0] magx, magy, magz;

	always_comb begin
		magx = div_out.side.dx[DW-1] ? DW'(-div_out.side.dx) : DW'(div_out.side.dx);
		magy = div_out.side.dy[DW-1] ? DW'(-div_out.side.dy) : DW'(div_out.side.dy);
		magz = div_out.side.dz[DW-1] ? DW'(-div_out.side.dz) : DW'(div_out.side.dz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s5 <= (2*QW)'(div_out.q) * (2*QW)'(magx);
			my_s5 <= (2*QW)'(div_out.q) * (2*QW)'(magy);
			mz_s5 <= (2*QW)'(div_out.q) * (2*QW)'(magz);
			side_s5 <= div_out.side;
		end
	end

	// Stage 38: round the offset to nearest and add it to p2, into the output register.
	function automatic logic [CW-1:0] epi_place(input logic [2*QW-1:0] m,
		input logic signed [CW-1:0] p2, input logic neg);
		logic [2*QW-1:0] rounded;
		logic signed [CW+1:0] off;
		logic signed [CW+1:0] r;
		rounded = m + (2*QW)'(64'h8000_0000);
		off = (CW+2)'(rounded >> 32);
		r = neg ? (CW+2)'(p2) - off : (CW+2)'(p2) + off;
		return r[CW-1:0];
	endfunction

	logic hit_q, last_q;
	logic [CW-1:0] cut_x_q, cut_y_q, cut_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= side_s5.hit;
			last_q <= side_s5.last;
			cut_x_q <= side_s5.hit ? epi_place(mx_s5, side_s5.p2x, side_s5.dx[DW-1]) : '0;
			cut_y_q <= side_s5.hit ? epi_place(my_s5, side_s5.p2y, side_s5.dy[DW-1]) : '0;
			cut_z_q <= side_s5.hit ? epi_place(mz_s5, side_s5.p2z, side_s5.dz[DW-1]) : '0;
		end
	end

	assign cut_out.valid = out_valid_q;
	assign cut_out.hit = hit_q;
	assign cut_out.cut_x = cut_x_q;
	assign cut_out.cut_y = cut_y_q;
	assign cut_out.cut_z = cut_z_q;
	assign cut_out.last_cut = last_q;

endmodule

@@ hw/rtl/epi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module epi_div (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  epi_pkg::epi_div_t in_data,
	output logic out_valid,
	output epi_pkg::epi_div_t out_data
);

	localparam int N = epi_pkg::FracBits;

	epi_pkg::epi_div_t stage_s [N+1];
	logic valid_s [N+1];

	assign stage_s[0] = in_data;
	assign valid_s[0] = in_valid;

	for (genvar j = 0; j < N; j++) begin : g_step
		logic [epi_pkg::SumW:0] shifted;
		logic take;
		epi_pkg::epi_div_t nxt;

		always_comb begin
			shifted = {stage_s[j].rem, 1'b0};
			take = shifted >= {1'b0, stage_s[j].dmag};
			nxt = stage_s[j];
			nxt.rem = take ? epi_pkg::SumW'(shifted - {1'b0, stage_s[j].dmag})
				: epi_pkg::SumW'(shifted);
			nxt.q = {stage_s[j].q[epi_pkg::QuoW-2:0], take};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (adv) begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stage_s[j+1] <= nxt;
			end
		end
	end

	assign out_valid = valid_s[N];
	assign out_data = stage_s[N];

endmodule
